// ===== rtl/flrx_pkg.sv =====
// flrx_pkg: shared codes, widths and the crc-8 step for the framed link receiver
`default_nettype none
package flrx_pkg;

  localparam int BYTE_W   = 8;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 9;
  localparam int CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0]  FRAME_MAGIC = 8'h55;
  localparam logic [BYTE_W-1:0]  CRC_POLY    = 8'h31;
  localparam logic [BYTE_W-1:0]  CRC_INIT    = 8'hFF;
  localparam logic [COUNT_W-1:0] HDR_BYTES   = 9'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECT_REPLY  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd3;

  localparam logic [BYTE_W-1:0] MAX_LEN_RST       = 8'd255;
  localparam logic [BYTE_W-1:0] TIMEOUT_TICKS_RST = 8'd20;

  // link events
  localparam logic [CMD_W-1:0] CMD_BEGIN_SEND = 3'd0;
  localparam logic [CMD_W-1:0] CMD_BEGIN_RECV = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SEND_DONE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_BYTE       = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TICK       = 3'd4;
  localparam logic [CMD_W-1:0] CMD_LINE_ERR   = 3'd5;

  // exchange outcome
  localparam logic [STATUS_W-1:0] ST_BUSY    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ERROR   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CRC     = 3'd4;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_RX   = 3'b010,
    MODE_TX   = 3'b100
  } mode_t;

  // msb-first crc-8, one byte
  function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    c = crc ^ b;
    for (int i = 0; i < BYTE_W; i++) begin
      c = c[BYTE_W-1] ? ({c[BYTE_W-2:0], 1'b0} ^ CRC_POLY) : {c[BYTE_W-2:0], 1'b0};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/framed_link_receiver_crc8_retry.sv =====
// framed_link_receiver_crc8_retry: link event decoder, reply deframer, crc check and retry
//
// in channel: one link event per item (cmd in in_tuser, received byte in in_tdata).
// out channel: exactly one result item per input item, in order. out_tlast marks the
//   item that ends an exchange, out_tuser marks an item that carries a payload byte.
// cfg port: cfg_we/cfg_addr/cfg_wdata write max_len, retry_limit, expect_reply and
//   timeout_ticks; write only while no exchange is in progress.
// an item's result is registered onto the out channel in the cycle after it is accepted.
// throughput: one item per cycle unless stalled; all state (mode, byte count, running crc,
//   timer, retries) is updated by one pass of combinational logic at the accepting edge.
// stall: the result register holds its item while out_tready is low; in_tready stays
//   high as long as the result register is empty or being emptied in the same cycle,
//   so an item can be taken while the previous result leaves.
// reset: rst_n low empties the result register and returns the block to idle with
//   status ok and registers at max_len 255, retry_limit 0, expect_reply 0,
//   timeout_ticks 20.
`default_nettype none
module framed_link_receiver_crc8_retry
  import flrx_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [7:0]           in_tdata,   // data_byte[7:0]
  input  wire logic [CMD_W-1:0]     in_tuser,   // cmd[2:0]
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // status[2:0], payload_byte[10:3], payload_index[18:11], frame_len[26:19],
  // retransmit[27], rejected[28], zero[31:29]
  output logic [31:0]               out_tdata,
  output logic                      out_tuser,  // payload_valid[0]
  output logic                      out_tlast,  // frame_done
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [BYTE_W-1:0]    cfg_wdata
);

  // configuration
  logic [BYTE_W-1:0] max_len_r, retry_limit_r, timeout_ticks_r;
  logic              expect_reply_r;

  // exchange state
  mode_t              mode_r, mode_nxt;
  logic [COUNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [BYTE_W-1:0]  header_len_r, header_len_nxt;
  logic [BYTE_W-1:0]  expected_crc_r, expected_crc_nxt;
  logic [BYTE_W-1:0]  running_crc_r, running_crc_nxt;
  logic [BYTE_W-1:0]  retries_left_r, retries_left_nxt;
  logic [BYTE_W-1:0]  timer_r, timer_nxt;
  logic [STATUS_W-1:0] last_status_r, last_status_nxt;

  // result register
  logic        out_valid_r;
  logic [31:0] out_data_r, out_data_nxt;
  logic        out_user_r, out_user_nxt;
  logic        out_last_r, out_last_nxt;

  logic               accept;
  logic               pvalid, done, retx, rej;
  logic [BYTE_W-1:0]  pbyte, pindex;
  logic [COUNT_W-1:0] payload_off;
  logic [COUNT_W:0]   frame_end;
  logic [STATUS_W-1:0] status;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  assign payload_off = byte_count_r - HDR_BYTES;

  always_comb begin
    mode_nxt         = mode_r;
    byte_count_nxt   = byte_count_r;
    header_len_nxt   = header_len_r;
    expected_crc_nxt = expected_crc_r;
    running_crc_nxt  = running_crc_r;
    retries_left_nxt = retries_left_r;
    timer_nxt        = timer_r;
    last_status_nxt  = last_status_r;
    pvalid = 1'b0;
    pbyte  = '0;
    pindex = '0;
    done   = 1'b0;
    retx   = 1'b0;
    rej    = 1'b0;
    frame_end = '0;

    case (in_tuser)
      CMD_BEGIN_SEND: begin
        if (mode_r != MODE_IDLE || (retry_limit_r != '0 && !expect_reply_r)) begin
          rej = 1'b1;
        end else begin
          retries_left_nxt = retry_limit_r;
          mode_nxt         = MODE_TX;
        end
      end
      CMD_BEGIN_RECV: begin
        if (mode_r != MODE_IDLE) begin
          rej = 1'b1;
        end else begin
          retries_left_nxt = '0;
          byte_count_nxt   = '0;
          running_crc_nxt  = CRC_INIT;
          timer_nxt        = timeout_ticks_r;
          mode_nxt         = MODE_RX;
        end
      end
      CMD_SEND_DONE: begin
        if (mode_r == MODE_TX) begin
          if (expect_reply_r) begin
            byte_count_nxt  = '0;
            running_crc_nxt = CRC_INIT;
            timer_nxt       = timeout_ticks_r;
            mode_nxt        = MODE_RX;
          end else begin
            last_status_nxt = ST_OK;
            mode_nxt        = MODE_IDLE;
            done            = 1'b1;
          end
        end
      end
      CMD_BYTE: begin
        if (mode_r == MODE_RX) begin
          if (byte_count_r == '0 && in_tdata != FRAME_MAGIC) begin
            // hunting for the magic: other bytes leave everything alone
          end else if (byte_count_r == 9'd1 && in_tdata > max_len_r) begin
            last_status_nxt = ST_ERROR;
            mode_nxt        = MODE_IDLE;
            done            = 1'b1;
          end else begin
            if (byte_count_r == 9'd1) begin
              header_len_nxt = in_tdata;
            end else if (byte_count_r == 9'd2) begin
              expected_crc_nxt = in_tdata;
            end else if (byte_count_r != '0 && payload_off < {1'b0, header_len_r}) begin
              pvalid          = 1'b1;
              pbyte           = in_tdata;
              pindex          = payload_off[BYTE_W-1:0];
              running_crc_nxt = crc8_step(running_crc_r, in_tdata);
            end
            timer_nxt      = timeout_ticks_r;
            byte_count_nxt = byte_count_r + 9'd1;
            // last byte of the frame, or crc byte of an empty one
            frame_end = {1'b0, header_len_nxt} + {1'b0, HDR_BYTES};
            if ({1'b0, byte_count_nxt} >= frame_end) begin
              last_status_nxt = (running_crc_nxt == expected_crc_nxt) ? ST_OK : ST_CRC;
              mode_nxt        = MODE_IDLE;
              done            = 1'b1;
            end
          end
        end
      end
      CMD_TICK: begin
        if (mode_r == MODE_RX) begin
          if (timer_r <= 8'd1) begin
            if (retries_left_r != '0) begin
              retries_left_nxt = retries_left_r - 8'd1;
              retx             = 1'b1;
              mode_nxt         = MODE_TX;
            end else begin
              last_status_nxt = ST_TIMEOUT;
              mode_nxt        = MODE_IDLE;
              done            = 1'b1;
            end
          end else begin
            timer_nxt = timer_r - 8'd1;
          end
        end
      end
      CMD_LINE_ERR: begin
        done            = (mode_r != MODE_IDLE);
        last_status_nxt = ST_ERROR;
        mode_nxt        = MODE_IDLE;
      end
      default: begin
      end
    endcase

    status       = (mode_nxt != MODE_IDLE) ? ST_BUSY : last_status_nxt;
    out_data_nxt = {3'b000, rej, retx, header_len_nxt, pindex, pbyte, status};
    out_user_nxt = pvalid;
    out_last_nxt = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r       <= MAX_LEN_RST;
      retry_limit_r   <= '0;
      expect_reply_r  <= 1'b0;
      timeout_ticks_r <= TIMEOUT_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MAX_LEN:       max_len_r       <= cfg_wdata;
        CFG_RETRY_LIMIT:   retry_limit_r   <= cfg_wdata;
        CFG_EXPECT_REPLY:  expect_reply_r  <= cfg_wdata[0];
        CFG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_IDLE;
      byte_count_r   <= '0;
      header_len_r   <= '0;
      expected_crc_r <= '0;
      running_crc_r  <= CRC_INIT;
      retries_left_r <= '0;
      timer_r        <= '0;
      last_status_r  <= ST_OK;
      out_valid_r    <= 1'b0;
    end else begin
      if (accept) begin
        mode_r         <= mode_nxt;
        byte_count_r   <= byte_count_nxt;
        header_len_r   <= header_len_nxt;
        expected_crc_r <= expected_crc_nxt;
        running_crc_r  <= running_crc_nxt;
        retries_left_r <= retries_left_nxt;
        timer_r        <= timer_nxt;
        last_status_r  <= last_status_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
      out_last_r <= out_last_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== verif/tb_framed_link_receiver_crc8_retry.sv =====
// testbench for the framed link receiver: directed and guided random link traffic, scoreboarded
`timescale 1ns / 100ps
module tb_framed_link_receiver_crc8_retry;
  import flrx_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int STUCK_LIMIT     = 3000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                pvalid;
    logic [7:0]          pbyte;
    logic [7:0]          pindex;
    logic [7:0]          flen;
    logic                done;
    logic                retx;
    logic                rej;
  } link_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata = 8'h00;
  logic [CMD_W-1:0]     in_tuser = CMD_TICK;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [31:0]          out_tdata;
  logic                 out_tuser;
  logic                 out_tlast;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = CFG_MAX_LEN;
  logic [BYTE_W-1:0]    cfg_wdata = 8'h00;

  // receiver state as predicted
  mode_t               rx_mode = MODE_IDLE;
  logic [COUNT_W-1:0]  rx_count = '0;
  logic [7:0]          hdr_len = 8'h00;
  logic [7:0]          hdr_crc = 8'h00;
  logic [7:0]          run_crc = CRC_INIT;
  logic [7:0]          retries_left = 8'h00;
  logic [7:0]          tick_timer = 8'h00;
  logic [STATUS_W-1:0] last_outcome = ST_OK;

  // register copies
  logic [7:0] lim_max_len = MAX_LEN_RST;
  logic [7:0] lim_retry = 8'h00;
  logic       lim_expect = 1'b0;
  logic [7:0] lim_timeout = TIMEOUT_TICKS_RST;

  link_result_t pending_results[$];
  int           n_errors = 0;
  int           stuck_cycles = 0;
  bit           no_idle = 1'b0;
  bit           hold_off_armed = 1'b0;

  // reply frame being sent by the random traffic
  logic [7:0] plan_len;
  logic [7:0] plan_crc;
  logic [7:0] frame_plan [0:254];

  framed_link_receiver_crc8_retry u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // data_byte[7:0]
    .in_tuser   (in_tuser),   // cmd[2:0]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    // status[2:0], payload_byte[10:3], payload_index[18:11], frame_len[26:19],
    // retransmit[27], rejected[28], zero[31:29]
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),  // payload_valid[0]
    .out_tlast  (out_tlast),  // frame_done
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // bit-serial form of the msb-first crc
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] acc;
    acc = crc;
    for (int k = 7; k >= 0; k--) begin
      if (acc[7] ^ data[k]) acc = {acc[6:0], 1'b0} ^ CRC_POLY;
      else acc = {acc[6:0], 1'b0};
    end
    return acc;
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 16);
  endfunction

  task automatic close_exchange(input logic [STATUS_W-1:0] outcome);
    last_outcome = outcome;
    rx_mode = MODE_IDLE;
  endtask

  task automatic arm_reception();
    rx_count = '0;
    run_crc = CRC_INIT;
    tick_timer = lim_timeout;
    rx_mode = MODE_RX;
  endtask

  task automatic predict_link_event(input logic [CMD_W-1:0] cmd, input logic [7:0] data);
    link_result_t r;
    int pos;
    bit take;
    r = '0;
    case (cmd)
      CMD_BEGIN_SEND: begin
        if (rx_mode != MODE_IDLE || (lim_retry != 8'd0 && !lim_expect)) begin
          r.rej = 1'b1;
        end else begin
          retries_left = lim_retry;
          rx_mode = MODE_TX;
        end
      end
      CMD_BEGIN_RECV: begin
        if (rx_mode != MODE_IDLE) begin
          r.rej = 1'b1;
        end else begin
          retries_left = 8'd0;
          arm_reception();
        end
      end
      CMD_SEND_DONE: begin
        if (rx_mode == MODE_TX) begin
          if (lim_expect) begin
            arm_reception();
          end else begin
            close_exchange(ST_OK);
            r.done = 1'b1;
          end
        end
      end
      CMD_BYTE: begin
        if (rx_mode == MODE_RX) begin
          take = 1'b1;
          pos = int'(rx_count) - 3;
          if (rx_count == 0) begin
            take = (data == FRAME_MAGIC);
          end else if (rx_count == 1) begin
            if (data > lim_max_len) begin
              close_exchange(ST_ERROR);
              r.done = 1'b1;
              take = 1'b0;
            end else begin
              hdr_len = data;
            end
          end else if (rx_count == 2) begin
            hdr_crc = data;
          end else if (pos < int'(hdr_len)) begin
            r.pvalid = 1'b1;
            r.pbyte = data;
            r.pindex = pos[7:0];
            run_crc = crc8_next(run_crc, data);
          end
          if (take) begin
            tick_timer = lim_timeout;
            rx_count = rx_count + 1'b1;
            if (int'(rx_count) - 3 >= int'(hdr_len)) begin
              close_exchange((run_crc == hdr_crc) ? ST_OK : ST_CRC);
              r.done = 1'b1;
            end
          end
        end
      end
      CMD_TICK: begin
        if (rx_mode == MODE_RX) begin
          if (tick_timer <= 8'd1) begin
            if (retries_left != 8'd0) begin
              retries_left = retries_left - 1'b1;
              r.retx = 1'b1;
              rx_mode = MODE_TX;
            end else begin
              close_exchange(ST_TIMEOUT);
              r.done = 1'b1;
            end
          end else begin
            tick_timer = tick_timer - 1'b1;
          end
        end
      end
      CMD_LINE_ERR: begin
        if (rx_mode != MODE_IDLE) r.done = 1'b1;
        close_exchange(ST_ERROR);
      end
      default: ;
    endcase
    r.status = (rx_mode != MODE_IDLE) ? ST_BUSY : last_outcome;
    r.flen = hdr_len;
    pending_results.push_back(r);
  endtask

  // valid stays high into the next item when there is no gap
  task automatic send_link_event(input logic [CMD_W-1:0] cmd, input logic [7:0] data);
    int gap;
    logic ready;
    gap = draw_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= data;
    do begin
      @(negedge clk);
      ready = in_tready;
      @(posedge clk);
    end while (!ready);
    predict_link_event(cmd, data);
  endtask

  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // closes any open exchange first, registers are only written while idle
  task automatic program_link(input logic [7:0] max_len, input logic [7:0] retry_limit,
                              input logic expect_reply, input logic [7:0] timeout_ticks);
    if (rx_mode != MODE_IDLE) send_link_event(CMD_LINE_ERR, 8'h00);
    wait_quiet();
    cfg_we <= 1'b1;
    cfg_addr <= CFG_MAX_LEN;
    cfg_wdata <= max_len;
    @(posedge clk);
    cfg_addr <= CFG_RETRY_LIMIT;
    cfg_wdata <= retry_limit;
    @(posedge clk);
    cfg_addr <= CFG_EXPECT_REPLY;
    cfg_wdata <= {7'd0, expect_reply};
    @(posedge clk);
    cfg_addr <= CFG_TIMEOUT_TICKS;
    cfg_wdata <= timeout_ticks;
    @(posedge clk);
    cfg_we <= 1'b0;
    lim_max_len = max_len;
    lim_retry = retry_limit;
    lim_expect = expect_reply;
    lim_timeout = timeout_ticks;
  endtask

  // picks each event from the predicted mode so most traffic forms real exchanges
  task automatic drive_link_traffic(input int budget);
    int sent;
    int roll;
    int k;
    logic [CMD_W-1:0] cmd;
    logic [7:0] b;
    bit counted;
    bit run_out;
    sent = 0;
    while (sent < budget) begin
      roll = $urandom_range(0, 99);
      cmd = CMD_W'($urandom_range(0, 7));
      b = 8'($urandom);
      counted = 1'b1;
      run_out = 1'b0;
      case (rx_mode)
        MODE_IDLE: begin
          if (roll < 45) cmd = CMD_BEGIN_RECV;
          else if (roll < 82) cmd = CMD_BEGIN_SEND;
          else if (roll < 86) cmd = CMD_LINE_ERR;
          else counted = 1'b0;
        end
        MODE_TX: begin
          if (roll < 88) cmd = CMD_SEND_DONE;
          else if (roll < 91) cmd = CMD_LINE_ERR;
          else counted = 1'b0;
        end
        default: begin
          if (roll < 3) begin
            run_out = 1'b1;
          end else if (rx_count == 0) begin
            if (roll < 58) begin
              cmd = CMD_BYTE;
              b = FRAME_MAGIC;
            end else if (roll < 76) begin
              cmd = CMD_BYTE;
              counted = 1'b0;
            end else if (roll < 96) begin
              cmd = CMD_TICK;
            end else begin
              counted = 1'b0;
            end
          end else if (roll < 85) begin
            cmd = CMD_BYTE;
            if (rx_count == 1) begin
              k = $urandom_range(0, 99);
              if (lim_max_len != 8'hFF && k < 6)
                plan_len = 8'($urandom_range(int'(lim_max_len) + 1, 255));
              else if (k < 10)
                plan_len = 8'($urandom_range(0, lim_max_len));
              else
                plan_len = 8'($urandom_range(0, (lim_max_len < 8'd8) ? lim_max_len : 8));
              plan_crc = CRC_INIT;
              for (k = 0; k < int'(plan_len); k++) begin
                frame_plan[k] = 8'($urandom);
                plan_crc = crc8_next(plan_crc, frame_plan[k]);
              end
              if ($urandom_range(0, 9) == 0) plan_crc = 8'($urandom);
              b = plan_len;
            end else if (rx_count == 2) begin
              b = plan_crc;
            end else begin
              b = frame_plan[int'(rx_count) - 3];
            end
          end else if (roll < 96) begin
            cmd = CMD_TICK;
          end else if (roll < 98) begin
            cmd = CMD_LINE_ERR;
          end else begin
            cmd = CMD_BEGIN_RECV;
          end
        end
      endcase
      if (run_out) begin
        // tick until the reply timer expires
        while (rx_mode == MODE_RX) begin
          send_link_event(CMD_TICK, 8'($urandom));
          sent++;
        end
      end else begin
        send_link_event(cmd, b);
        if (counted) sent++;
      end
    end
  endtask

  task automatic test_ignored_events();
    send_link_event(CMD_RSVD_6, 8'hFF);
    send_link_event(CMD_RSVD_7, 8'h00);
    send_link_event(CMD_SEND_DONE, 8'h55);
    send_link_event(CMD_BYTE, FRAME_MAGIC);
    send_link_event(CMD_TICK, 8'hFF);
    send_link_event(CMD_LINE_ERR, 8'h00);
  endtask

  task automatic test_frame_receive();
    send_link_event(CMD_BEGIN_RECV, 8'h00);
    send_link_event(CMD_BEGIN_RECV, 8'h00);
    send_link_event(CMD_BEGIN_SEND, 8'h00);
    send_link_event(CMD_BYTE, 8'h00);
    send_link_event(CMD_BYTE, FRAME_MAGIC);
    // empty payload, crc byte checked against the initial value
    send_link_event(CMD_BYTE, 8'h00);
    send_link_event(CMD_BYTE, 8'hFF);
    send_link_event(CMD_BEGIN_RECV, 8'h00);
    send_link_event(CMD_BYTE, FRAME_MAGIC);
    send_link_event(CMD_BYTE, 8'h01);
    send_link_event(CMD_BYTE, 8'h5A);
    send_link_event(CMD_BYTE, 8'h80);
  endtask

  task automatic test_send_and_timeout();
    send_link_event(CMD_BEGIN_SEND, 8'h00);
    send_link_event(CMD_SEND_DONE, 8'hA5);
    // retries without a reply are refused, zero length limit rejects any payload
    program_link(8'd0, 8'd1, 1'b0, 8'd0);
    send_link_event(CMD_BEGIN_SEND, 8'h00);
    send_link_event(CMD_BEGIN_RECV, 8'h00);
    send_link_event(CMD_BYTE, FRAME_MAGIC);
    send_link_event(CMD_BYTE, 8'h01);
    // zero timeout acts as one tick
    program_link(8'd0, 8'd1, 1'b1, 8'd0);
    send_link_event(CMD_BEGIN_SEND, 8'h00);
    send_link_event(CMD_SEND_DONE, 8'h00);
    send_link_event(CMD_TICK, 8'h00);
    send_link_event(CMD_SEND_DONE, 8'h00);
    send_link_event(CMD_TICK, 8'h00);
  endtask

  task automatic test_backpressure();
    no_idle = 1'b1;
    hold_off_armed = 1'b1;
    drive_link_traffic(24);
    no_idle = 1'b0;
    wait_quiet();
    drive_link_traffic(24);
  endtask

  task automatic test_random_traffic();
    program_link(8'd255, 8'd0, 1'b1, 8'd3);
    drive_link_traffic(230);
    program_link(8'd8, 8'd3, 1'b1, 8'd1);
    no_idle = 1'b1;
    drive_link_traffic(230);
    no_idle = 1'b0;
    program_link(8'd0, 8'd255, 1'b1, 8'd2);
    drive_link_traffic(200);
    program_link(8'd4, 8'd1, 1'b0, 8'd5);
    drive_link_traffic(200);
    program_link(8'd255, 8'd2, 1'b1, 8'd255);
    drive_link_traffic(150);
    repeat (3) begin
      program_link(8'($urandom_range(0, 255)), 8'($urandom_range(0, 4)),
                   1'($urandom_range(0, 1)), 8'($urandom_range(1, 8)));
      drive_link_traffic(150);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  task automatic check_link_result(input logic [31:0] data, input logic pv, input logic fd);
    link_result_t want;
    if (pending_results.size() == 0) begin
      $error("result item with nothing expected: tdata %h", data);
      n_errors++;
    end else begin
      want = pending_results.pop_front();
      check_field("status", 32'(want.status), 32'(data[2:0]));
      check_field("payload_valid", 32'(want.pvalid), 32'(pv));
      check_field("payload_byte", 32'(want.pbyte), 32'(data[10:3]));
      check_field("payload_index", 32'(want.pindex), 32'(data[18:11]));
      check_field("frame_len", 32'(want.flen), 32'(data[26:19]));
      check_field("frame_done", 32'(want.done), 32'(fd));
      check_field("retransmit", 32'(want.retx), 32'(data[27]));
      check_field("rejected", 32'(want.rej), 32'(data[28]));
      check_field("tdata pad", 0, 32'(data[31:29]));
    end
  endtask

  initial begin : result_sink
    int stall;
    logic got;
    logic [31:0] seen_data;
    logic seen_user;
    logic seen_last;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_armed) begin
        hold_off_armed = 1'b0;
        stall = HOLD_OFF_CYCLES;
      end else begin
        stall = draw_gap();
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do begin
        @(negedge clk);
        got = out_tvalid;
        seen_data = out_tdata;
        seen_user = out_tuser;
        seen_last = out_tlast;
        @(posedge clk);
      end while (!got);
      check_link_result(seen_data, seen_user, seen_last);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("tb_framed_link_receiver_crc8_retry: done, errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_ignored_events();
    test_frame_receive();
    test_send_and_timeout();
    test_backpressure();
    test_random_traffic();
    wait_quiet();
    if (n_errors == 0) begin
      $display("tb_framed_link_receiver_crc8_retry: done, clean");
    end else begin
      $display("tb_framed_link_receiver_crc8_retry: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/flrx_pkg.sv
rtl/framed_link_receiver_crc8_retry.sv
verif/tb_framed_link_receiver_crc8_retry.sv
